// ----- sv/deq_pkg.sv -----
// Shared types and constants of the double-ended queue.
package deq_pkg;

    // Default number of words the ring store holds.
    localparam int DEQ_DEPTH_DEF = 16;

    // Width of one stored word.
    localparam int WORD_W = 64;

    // The input word carries a 3-bit operation and a 64-bit value, padded to 72 bits.
    localparam int OP_W       = 3;
    localparam int IN_TDATA_W = ((OP_W + WORD_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_REVERSE    = 3'd4,
        OP_REPORT     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2
    } t_status;

    // Facts about one step that the result formatter needs, held in a register.
    typedef struct packed {
        logic    rev;
        logic    empty;
        t_status status;
    } t_step_info;

endpackage

// ----- sv/double_ended_queue_core.sv -----
// Top level of the bounded double-ended queue with one-step reverse.
//
// A bounded double-ended queue of 64-bit words held in a ring store of DEPTH
// entries. Each input word carries an operation (push front, push back, pop
// front, pop back, reverse, or report only) and a value, and produces exactly
// one result word with the front and back words, the count, an empty flag and
// a status. A push into a full queue is dropped with status overflow, a pop
// from an empty queue leaves it unchanged with status underflow, and front and
// back read as zero while the queue is empty. Reverse only toggles a direction
// flag, so it costs no more than any other operation. Each input word is handled
// in an accept step and a read step: in the accept step the head, count and
// direction registers update, a pushed word is written and both end slots are
// read from the store; in the read step the registered store read data is
// formatted into the output register once that register is free. A finished
// result may wait in the output register while the next input word is taken.
// The store needs no clearing after reset: only slots written by a push are
// ever shown.
module double_ended_queue_core #(
    parameter int DEPTH   = deq_pkg::DEQ_DEPTH_DEF,
    localparam int CW     = $clog2(DEPTH + 1),
    localparam int OUT_W  = ((2 * deq_pkg::WORD_W + CW + 3 + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input words.
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // From bit 0: operation (3), value (64), zero padding.
    input  logic [deq_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    // Result words.
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // From bit 0: front_value (64), back_value (64), entry_count (CW),
    // is_empty (1), status (2), zero padding.
    output logic [OUT_W-1:0]               o_m_axis_tdata
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state             r_state;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_tdata, n_out_tdata;

    logic               step;
    t_op                op;
    logic [WORD_W-1:0]  push_word;

    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr_low, rd_addr_high;
    logic [WORD_W-1:0]  rd_low, rd_high, front_w, back_w;
    logic [CW-1:0]      count;
    t_step_info         info;
    logic               out_free;

    // One word is in flight at a time; the state registers settle in the accept cycle.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign step            = i_s_axis_tvalid && o_s_axis_tready;
    assign op              = t_op'(i_s_axis_tdata[OP_W-1:0]);
    assign push_word       = i_s_axis_tdata[OP_W +: WORD_W];

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_op           (op),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_rd_addr_low  (rd_addr_low),
        .o_rd_addr_high (rd_addr_high),
        .o_count        (count),
        .o_info         (info)
    );

    // Both end slots are read on every accepted word, so the read data stays
    // valid until the next word is accepted.
    deq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (push_word),
        .i_rd_en     (step),
        .i_rd_addr_a (rd_addr_low),
        .i_rd_addr_b (rd_addr_high),
        .o_rd_data_a (rd_low),
        .o_rd_data_b (rd_high)
    );

    // The low slot is the front unless the queue is reversed; both ends read
    // as zero when nothing is held.
    always_comb begin
        front_w = '0;
        back_w  = '0;
        if (!info.empty) begin
            front_w = info.rev ? rd_high : rd_low;
            back_w  = info.rev ? rd_low : rd_high;
        end
        n_out_tdata                                = '0;
        n_out_tdata[0 +: WORD_W]                   = front_w;
        n_out_tdata[WORD_W +: WORD_W]              = back_w;
        n_out_tdata[2 * WORD_W +: CW]              = count;
        n_out_tdata[2 * WORD_W + CW]               = info.empty;
        n_out_tdata[2 * WORD_W + CW + 1 +: 2]      = info.status;
    end

    // The output register can take a new result when it is empty or is being drained.
    assign out_free = !r_out_valid || i_m_axis_tready;

    // In the read state the output register is either reloaded (when it is free)
    // or holds a stalled word, so a drain only needs handling in the idle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (step) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_tdata <= n_out_tdata;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;

    // The count never goes past the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(DEPTH))
        else $error("word count exceeds store depth");

    // An accepted word blocks the input until its result has been formed.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> !o_s_axis_tready)
        else $error("input accepted while a word is in flight");

    // The empty flag of a result agrees with its count.
    a_empty_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[2 * WORD_W + CW] == (o_m_axis_tdata[2 * WORD_W +: CW] == '0)))
        else $error("empty flag disagrees with count");

    // An empty queue shows zero at both ends.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2 * WORD_W + CW]) |->
            (o_m_axis_tdata[2 * WORD_W - 1:0] == '0))
        else $error("nonzero end words on an empty queue");

endmodule

// ----- sv/deq_ram.sv -----
// Ring store: one write port and two registered read ports, write-first.
module deq_ram #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH_DEF,
    parameter int WIDTH = deq_pkg::WORD_W,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // A read of the slot being written in the same cycle returns the new word.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr_a)) begin
                o_rd_data_a <= i_wr_data;
            end else begin
                o_rd_data_a <= mem[i_rd_addr_a];
            end
            if (i_wr_en && (i_wr_addr == i_rd_addr_b)) begin
                o_rd_data_b <= i_wr_data;
            end else begin
                o_rd_data_b <= mem[i_rd_addr_b];
            end
        end
    end

endmodule

// ----- sv/deq_ctrl.sv -----
// Queue bookkeeping: head slot, word count and direction flag, plus store addressing.
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  deq_pkg::t_op        i_op,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic [AW-1:0]       o_rd_addr_low,
    output logic [AW-1:0]       o_rd_addr_high,
    output logic [CW-1:0]       o_count,
    output deq_pkg::t_step_info o_info
);
    import deq_pkg::*;

    localparam int SW = AW + 1;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic          r_rev, n_rev;
    t_step_info    r_info;

    logic          full, empty, low_side, wr_en_c;
    t_status       status_c;
    logic [AW-1:0] head_inc, head_dec, tail_slot, wr_addr_c, high_slot;
    logic [SW-1:0] tail_sum, high_sum;
    logic [CW-1:0] count_m1;

    assign full     = (r_count == CW'(DEPTH));
    assign empty    = (r_count == '0);
    assign low_side = ((i_op == OP_PUSH_FRONT) || (i_op == OP_POP_FRONT)) ^ r_rev;
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);

    // Slot just past the last held word; only used when the store is not full.
    assign tail_sum  = {1'b0, r_head} + {1'b0, r_count[AW-1:0]};
    assign tail_slot = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : tail_sum[AW-1:0];

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_rev     = r_rev;
        status_c  = ST_DONE;
        wr_en_c   = 1'b0;
        wr_addr_c = tail_slot;
        unique case (i_op) inside
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
                if (full) begin
                    status_c = ST_OVER;
                end else begin
                    wr_en_c = 1'b1;
                    n_count = r_count + CW'(1);
                    if (low_side) begin
                        n_head    = head_dec;
                        wr_addr_c = head_dec;
                    end
                end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
                if (empty) begin
                    status_c = ST_UNDER;
                end else begin
                    n_count = r_count - CW'(1);
                    if (low_side) begin
                        n_head = head_inc;
                    end
                end
            end
            OP_REVERSE: begin
                n_rev = ~r_rev;
            end
            default: begin
            end
        endcase
    end

    // Last held slot after the step; meaningless when the queue ends up empty.
    assign count_m1  = n_count - CW'(1);
    assign high_sum  = {1'b0, n_head} + {1'b0, count_m1[AW-1:0]};
    assign high_slot = (high_sum >= SW'(DEPTH)) ? AW'(high_sum - SW'(DEPTH)) : high_sum[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
            r_info  <= '{rev: 1'b0, empty: 1'b1, status: ST_DONE};
        end else if (i_step) begin
            r_head  <= n_head;
            r_count <= n_count;
            r_rev   <= n_rev;
            r_info  <= '{rev: n_rev, empty: (n_count == '0), status: status_c};
        end
    end

    assign o_wr_en        = i_step && wr_en_c;
    assign o_wr_addr      = wr_addr_c;
    assign o_rd_addr_low  = n_head;
    assign o_rd_addr_high = high_slot;
    assign o_count        = r_count;
    assign o_info         = r_info;

endmodule

// ----- verif/double_ended_queue_checker.sv -----
// Checker that predicts and compares every result word of the double-ended queue.
module double_ended_queue_checker
    import deq_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int OUT_W = ((2 * WORD_W + CW + 3 + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_tvalid,
    input  logic                  i_in_tready,
    // From bit 0: operation (3), value (64), zero padding.
    input  logic [IN_TDATA_W-1:0] i_in_tdata,
    input  logic                  i_out_tvalid,
    input  logic                  i_out_tready,
    // From bit 0: front_value (64), back_value (64), entry_count (CW),
    // is_empty (1), status (2), zero padding.
    input  logic [OUT_W-1:0]      i_out_tdata,
    output int                    o_pending,
    output int                    o_fail_count
);

    typedef struct packed {
        logic [WORD_W-1:0] front;
        logic [WORD_W-1:0] back;
        logic [CW-1:0]     count;
        logic              empty;
        t_status           status;
    } t_result;

    // Our own copy of the ring store and its pointers.
    logic [WORD_W-1:0] ring_words [DEPTH];
    int                ring_head;
    int                ring_count;
    logic              ring_reversed;

    t_result pending_results [$];
    t_result predicted;
    t_result observed;
    int      fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        $display("mismatch %s: got %h, expected %h", what, got, want);
        fail_count++;
    endtask

    // Applies one operation to the ring copy and returns the result word it should give.
    task automatic compute_step_result(input logic [OP_W-1:0] op,
                                       input logic [WORD_W-1:0] val, output t_result res);
        logic [WORD_W-1:0] low_word;
        logic [WORD_W-1:0] high_word;
        t_status           st;
        st        = ST_DONE;
        low_word  = '0;
        high_word = '0;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
            if (ring_count >= DEPTH) begin
                st = ST_OVER;
            end else if ((op == OP_PUSH_FRONT) != ring_reversed) begin
                ring_head = (ring_head + DEPTH - 1) % DEPTH;
                ring_words[ring_head] = val;
                ring_count++;
            end else begin
                ring_words[(ring_head + ring_count) % DEPTH] = val;
                ring_count++;
            end
        end else if (op == OP_POP_FRONT || op == OP_POP_BACK) begin
            if (ring_count == 0) begin
                st = ST_UNDER;
            end else if ((op == OP_POP_FRONT) != ring_reversed) begin
                ring_head = (ring_head + 1) % DEPTH;
                ring_count--;
            end else begin
                ring_count--;
            end
        end else if (op == OP_REVERSE) begin
            ring_reversed = ~ring_reversed;
        end
        // Report, and the two unused codes, leave everything as it is.
        if (ring_count != 0) begin
            low_word  = ring_words[ring_head];
            high_word = ring_words[(ring_head + ring_count - 1) % DEPTH];
        end
        res.front  = ring_reversed ? high_word : low_word;
        res.back   = ring_reversed ? low_word : high_word;
        res.count  = CW'(ring_count);
        res.empty  = (ring_count == 0);
        res.status = st;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_head     = 0;
            ring_count    = 0;
            ring_reversed = 1'b0;
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_in_tvalid && i_in_tready) begin
                compute_step_result(i_in_tdata[OP_W-1:0], i_in_tdata[OP_W +: WORD_W],
                                    predicted);
                pending_results.push_back(predicted);
            end
            if (i_out_tvalid && i_out_tready) begin
                observed.front  = i_out_tdata[0 +: WORD_W];
                observed.back   = i_out_tdata[WORD_W +: WORD_W];
                observed.count  = i_out_tdata[2 * WORD_W +: CW];
                observed.empty  = i_out_tdata[2 * WORD_W + CW];
                observed.status = t_status'(i_out_tdata[2 * WORD_W + CW + 1 +: 2]);
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result word", observed.front, '0);
                end else begin
                    predicted = pending_results.pop_front();
                    if (observed.front !== predicted.front) begin
                        report_mismatch("front_value", observed.front, predicted.front);
                    end
                    if (observed.back !== predicted.back) begin
                        report_mismatch("back_value", observed.back, predicted.back);
                    end
                    if (observed.count !== predicted.count) begin
                        report_mismatch("entry_count", WORD_W'(observed.count),
                                        WORD_W'(predicted.count));
                    end
                    if (observed.empty !== predicted.empty) begin
                        report_mismatch("is_empty", WORD_W'(observed.empty),
                                        WORD_W'(predicted.empty));
                    end
                    if (observed.status !== predicted.status) begin
                        report_mismatch("status", WORD_W'(observed.status),
                                        WORD_W'(predicted.status));
                    end
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

// ----- verif/double_ended_queue_core_tb.sv -----
// Testbench top that drives operation words into the double-ended queue and gives the verdict.
module double_ended_queue_core_tb;
    import deq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int OUT_W = ((2 * WORD_W + CW + 3 + 7) / 8) * 8;

    // Number of random words sent in each of the four idling phases.
    localparam int PHASE_WORDS = 480;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_W-1:0]      m_axis_tdata;

    int pending_count;
    int fail_count;

    // Chances in a hundred that the sender idles or the receiver stalls in a cycle.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Share of pushes among pushes and pops; flipped now and then so the queue
    // swings between full and empty.
    int push_pct = 70;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    double_ended_queue_core #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_axis_tvalid),
        .o_s_axis_tready(s_axis_tready),
        .i_s_axis_tdata (s_axis_tdata),
        .o_m_axis_tvalid(m_axis_tvalid),
        .i_m_axis_tready(m_axis_tready),
        .o_m_axis_tdata (m_axis_tdata)
    );

    double_ended_queue_checker #(
        .DEPTH(DEPTH),
        .CW   (CW),
        .OUT_W(OUT_W)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_tvalid (s_axis_tvalid),
        .i_in_tready (s_axis_tready),
        .i_in_tdata  (s_axis_tdata),
        .i_out_tvalid(m_axis_tvalid),
        .i_out_tready(m_axis_tready),
        .i_out_tdata (m_axis_tdata),
        .o_pending   (pending_count),
        .o_fail_count(fail_count)
    );

    // The receiver decides afresh every cycle whether to stall.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Presents one operation word and holds it until the queue takes it. The
    // valid is only raised here and never lowered in the step it is raised.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - OP_W - WORD_W){1'b0}}, val, op};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Stops sending and waits until every predicted result word has come back.
    task automatic drain_results;
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending_count != 0);
    endtask

    // Picks a value that mixes plain random words with zero, all ones and single bits.
    function automatic logic [WORD_W-1:0] pick_value();
        logic [WORD_W-1:0] val;
        case ($urandom_range(7))
            0: begin
                val = '0;
            end
            1: begin
                val = '1;
            end
            2: begin
                val = WORD_W'(1) << $urandom_range(WORD_W - 1);
            end
            default: begin
                val = {$urandom, $urandom};
            end
        endcase
        return val;
    endfunction

    // Picks an operation: mostly pushes and pops with a drifting bias, plus
    // reverses, reports and the two unused codes.
    function automatic logic [OP_W-1:0] pick_operation();
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return OP_REVERSE;
        end else if (roll < 12) begin
            return OP_REPORT;
        end else if (roll < 14) begin
            return OP_W'($urandom_range(7, 6));
        end else if ($urandom_range(99) < push_pct) begin
            return ($urandom_range(1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        end else begin
            return ($urandom_range(1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
        end
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: both pops and two reverses on an empty queue, report and
        // the unused codes, then fill to the brim with extreme and mixed values, push
        // twice more so both ends overflow, then reverse and pop at both ends.
        send_word(OP_POP_FRONT, '1);
        send_word(OP_POP_BACK, '0);
        send_word(OP_REVERSE, '0);
        send_word(OP_REVERSE, '1);
        send_word(OP_REPORT, {$urandom, $urandom});
        send_word(3'd6, '1);
        send_word(3'd7, '0);
        send_word(OP_PUSH_FRONT, '0);
        send_word(OP_PUSH_BACK, '1);
        for (int i = 0; i < DEPTH - 2; i++) begin
            if (i % 2 == 0) begin
                send_word(OP_PUSH_FRONT, (i % 4 == 0) ? 64'haaaa_aaaa_aaaa_aaaa
                                                      : {$urandom, $urandom});
            end else begin
                send_word(OP_PUSH_BACK, (i % 4 == 1) ? 64'h5555_5555_5555_5555
                                                     : {$urandom, $urandom});
            end
        end
        send_word(OP_PUSH_BACK, {$urandom, $urandom});
        send_word(OP_PUSH_FRONT, {$urandom, $urandom});
        send_word(OP_REVERSE, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_BACK, '0);
        drain_results();

        // Random part, in four idling phases. The results drain fully between
        // phases so the sender waits out every outstanding result at least once.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(39) == 0) begin
                    push_pct = 100 - push_pct;
                end
                send_word(pick_operation(), pick_value());
            end
            drain_results();
        end

        // Let any stray result word show up before the verdict.
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS double_ended_queue_core");
        end else begin
            $display("FAIL double_ended_queue_core");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL double_ended_queue_core");
        $finish;
    end

endmodule
